[rtl/core/pfd_pkg.sv]
package pfd_pkg;

    localparam int FRAC_BITS_DEF = 16;

    localparam int SAMPLE_W   = 32;
    localparam int ERR_W      = 33;
    localparam int DIFF_W     = 34;
    localparam int TERM_W     = 48;
    localparam int OPB_W      = 49;
    localparam int TOTAL_W    = 50;
    localparam int MUL_A_W    = 33;
    localparam int CHUNK_W    = 34;
    localparam int MUL_B_W    = 35;
    localparam int ACC_W      = 68;
    localparam int BLEND_BITS = 16;
    localparam int BLEND_W    = 17;
    localparam int LIMIT_W    = 31;
    localparam int CMD_W      = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [BLEND_W-1:0] BLEND_ONE = 17'h10000;

    localparam logic [CMD_W-1:0] CMD_COMPUTE = 2'd0;
    localparam logic [CMD_W-1:0] CMD_CLEAR   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_RESET   = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_PROP_GAIN   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INTEG_GAIN  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DERIV_GAIN  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DERIV_BLEND = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_INTEG_LIMIT = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_OUT_LIMIT   = 3'd5;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_SUM,
        ST_P_MUL,
        ST_P_ACC,
        ST_I_LOAD,
        ST_I_MUL,
        ST_I_ACC,
        ST_D_LOAD,
        ST_D_MUL,
        ST_D_ACC,
        ST_D_STORE,
        ST_B_LOAD,
        ST_B_MUL0,
        ST_B_MUL1,
        ST_B_ACC,
        ST_B_STORE,
        ST_TOTAL,
        ST_OUT
    } pfd_state_t;

    typedef enum logic [1:0] {
        OP_P,
        OP_I,
        OP_D,
        OP_B
    } pfd_op_t;

    typedef enum logic [1:0] {
        DST_P,
        DST_I,
        DST_RAW
    } pfd_dst_t;

    typedef struct packed {
        logic     err_load;
        logic     sum_update;
        logic     sum_clear;
        logic     state_clear;
        logic     op_load;
        pfd_op_t  op;
        logic     mul_en;
        logic     mul_last;
        logic     acc_en;
        logic     store_en;
        pfd_dst_t dst;
        logic     hist_update;
        logic     total_load;
        logic     out_load;
    } pfd_cmd_t;

endpackage

[rtl/core/pfd_ctrl.sv]
module pfd_ctrl (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    input  logic [pfd_pkg::CMD_W-1:0] s_command,
    output logic                      s_ready,
    output logic                      m_valid,
    input  logic                      m_ready,
    output pfd_pkg::pfd_cmd_t         cmd
);
    import pfd_pkg::*;

    pfd_state_t state_reg, state_next;
    logic       m_valid_reg, m_valid_next;
    logic       accept;

    assign s_ready = (state_reg == ST_IDLE);
    assign accept  = s_valid && s_ready;
    assign m_valid = m_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept && s_command == CMD_COMPUTE) begin
                    state_next = ST_SUM;
                end
            end
            ST_SUM:     state_next = ST_P_MUL;
            ST_P_MUL:   state_next = ST_P_ACC;
            ST_P_ACC:   state_next = ST_I_LOAD;
            ST_I_LOAD:  state_next = ST_I_MUL;
            ST_I_MUL:   state_next = ST_I_ACC;
            ST_I_ACC:   state_next = ST_D_LOAD;
            ST_D_LOAD:  state_next = ST_D_MUL;
            ST_D_MUL:   state_next = ST_D_ACC;
            ST_D_ACC:   state_next = ST_D_STORE;
            ST_D_STORE: state_next = ST_B_LOAD;
            ST_B_LOAD:  state_next = ST_B_MUL0;
            ST_B_MUL0:  state_next = ST_B_MUL1;
            ST_B_MUL1:  state_next = ST_B_ACC;
            ST_B_ACC:   state_next = ST_B_STORE;
            ST_B_STORE: state_next = ST_TOTAL;
            ST_TOTAL:   state_next = ST_OUT;
            ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default:    state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd = '0;
        cmd.op  = OP_P;
        cmd.dst = DST_P;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    case (s_command)
                        CMD_COMPUTE: cmd.err_load    = 1'b1;
                        CMD_CLEAR:   cmd.sum_clear   = 1'b1;
                        CMD_RESET:   cmd.state_clear = 1'b1;
                        default:     cmd.err_load    = 1'b0;
                    endcase
                end
            end
            ST_SUM: begin
                cmd.sum_update = 1'b1;
                cmd.op_load    = 1'b1;
                cmd.op         = OP_P;
            end
            ST_P_MUL, ST_I_MUL, ST_D_MUL: begin
                cmd.mul_en   = 1'b1;
                cmd.mul_last = 1'b1;
            end
            ST_B_MUL0: begin
                cmd.mul_en = 1'b1;
            end
            ST_B_MUL1: begin
                // low chunk product is added while the high chunk multiplies
                cmd.mul_en   = 1'b1;
                cmd.mul_last = 1'b1;
                cmd.acc_en   = 1'b1;
            end
            ST_P_ACC, ST_I_ACC, ST_D_ACC, ST_B_ACC: begin
                cmd.acc_en = 1'b1;
            end
            ST_I_LOAD: begin
                cmd.store_en = 1'b1;
                cmd.dst      = DST_P;
                cmd.op_load  = 1'b1;
                cmd.op       = OP_I;
            end
            ST_D_LOAD: begin
                cmd.store_en = 1'b1;
                cmd.dst      = DST_I;
                cmd.op_load  = 1'b1;
                cmd.op       = OP_D;
            end
            ST_D_STORE: begin
                cmd.store_en = 1'b1;
                cmd.dst      = DST_RAW;
            end
            ST_B_LOAD: begin
                cmd.op_load = 1'b1;
                cmd.op      = OP_B;
            end
            ST_B_STORE: begin
                cmd.hist_update = 1'b1;
            end
            ST_TOTAL: begin
                cmd.total_load = 1'b1;
            end
            ST_OUT: begin
                cmd.out_load = !m_valid_reg || m_ready;
            end
            default: begin
                cmd.err_load = 1'b0;
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

endmodule

[rtl/core/pfd_dpath.sv]
module pfd_dpath #(
    parameter int FRAC_BITS = pfd_pkg::FRAC_BITS_DEF
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  pfd_pkg::pfd_cmd_t                     cmd,
    input  logic signed [pfd_pkg::SAMPLE_W-1:0]   s_target,
    input  logic signed [pfd_pkg::SAMPLE_W-1:0]   s_measured,
    input  logic                                  cfg_we,
    input  logic [pfd_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [pfd_pkg::CFG_DATA_W-1:0]        cfg_data,
    output logic signed [pfd_pkg::SAMPLE_W-1:0]   m_drive
);
    import pfd_pkg::*;

    // configuration
    logic signed [SAMPLE_W-1:0] prop_gain_reg, integ_gain_reg, deriv_gain_reg;
    logic [BLEND_W-1:0]         deriv_blend_reg;
    logic [LIMIT_W-1:0]         integ_limit_reg, out_limit_reg;

    // loop state
    logic signed [ERR_W-1:0]    error_sum_reg, prev_error_reg;
    logic signed [TERM_W-1:0]   prev_deriv_reg;

    // working registers
    logic signed [ERR_W-1:0]    err_reg;
    logic signed [MUL_A_W-1:0]  a_reg, a_next;
    logic signed [OPB_W-1:0]    b_reg, b_next;
    logic signed [ACC_W-1:0]    prod_reg, prod_next;
    logic                       prod_hi_reg, mul_idx_reg;
    logic signed [ACC_W-1:0]    acc_reg, acc_init;
    logic signed [TERM_W-1:0]   p_term_reg, i_term_reg, raw_reg;
    logic signed [TOTAL_W-1:0]  total_reg, total_next;
    logic signed [SAMPLE_W-1:0] drive_reg;

    logic signed [ERR_W-1:0]    err_next;
    logic signed [DIFF_W-1:0]   sum_wide, ilim, sum_clamped;
    logic signed [DIFF_W-1:0]   err_diff;
    logic signed [OPB_W-1:0]    blend_diff;
    logic [BLEND_W-1:0]         blend_w;
    logic signed [MUL_B_W-1:0]  mul_b;
    logic signed [ACC_W-1:0]    prod_shift;
    logic signed [ACC_W-1:0]    q_shift, blend_shift;
    logic signed [TERM_W-1:0]   q_sat;
    logic                       q_in_range;
    logic signed [TOTAL_W-1:0]  olim, out_clamped;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prop_gain_reg   <= '0;
            integ_gain_reg  <= '0;
            deriv_gain_reg  <= '0;
            deriv_blend_reg <= BLEND_ONE;
            integ_limit_reg <= {LIMIT_W{1'b1}};
            out_limit_reg   <= {LIMIT_W{1'b1}};
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_PROP_GAIN:   prop_gain_reg   <= cfg_data;
                CFG_INTEG_GAIN:  integ_gain_reg  <= cfg_data;
                CFG_DERIV_GAIN:  deriv_gain_reg  <= cfg_data;
                CFG_DERIV_BLEND: deriv_blend_reg <= cfg_data[BLEND_W-1:0];
                CFG_INTEG_LIMIT: integ_limit_reg <= cfg_data[LIMIT_W-1:0];
                CFG_OUT_LIMIT:   out_limit_reg   <= cfg_data[LIMIT_W-1:0];
                default:         prop_gain_reg   <= prop_gain_reg;
            endcase
        end
    end

    assign err_next = {s_target[SAMPLE_W-1], s_target} - {s_measured[SAMPLE_W-1], s_measured};

    // error sum with symmetric clamp
    assign sum_wide = {error_sum_reg[ERR_W-1], error_sum_reg} + {err_reg[ERR_W-1], err_reg};
    assign ilim     = {{(DIFF_W-LIMIT_W){1'b0}}, integ_limit_reg};

    always_comb begin
        if (sum_wide > ilim) begin
            sum_clamped = ilim;
        end else if (sum_wide < -ilim) begin
            sum_clamped = -ilim;
        end else begin
            sum_clamped = sum_wide;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            error_sum_reg  <= '0;
            prev_error_reg <= '0;
            prev_deriv_reg <= '0;
        end else if (cmd.state_clear) begin
            error_sum_reg  <= '0;
            prev_error_reg <= '0;
            prev_deriv_reg <= '0;
        end else begin
            if (cmd.sum_clear) begin
                error_sum_reg <= '0;
            end else if (cmd.sum_update) begin
                error_sum_reg <= sum_clamped[ERR_W-1:0];
            end
            if (cmd.hist_update) begin
                prev_error_reg <= err_reg;
                prev_deriv_reg <= blend_shift[TERM_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.err_load) begin
            err_reg <= err_next;
        end
    end

    // operand selection
    assign err_diff   = {err_reg[ERR_W-1], err_reg} - {prev_error_reg[ERR_W-1], prev_error_reg};
    assign blend_diff = {raw_reg[TERM_W-1], raw_reg} - {prev_deriv_reg[TERM_W-1], prev_deriv_reg};
    assign blend_w    = (deriv_blend_reg > BLEND_ONE) ? BLEND_ONE : deriv_blend_reg;

    always_comb begin
        a_next   = '0;
        b_next   = '0;
        acc_init = '0;
        case (cmd.op)
            OP_P: begin
                a_next = {prop_gain_reg[SAMPLE_W-1], prop_gain_reg};
                b_next = {{(OPB_W-ERR_W){err_reg[ERR_W-1]}}, err_reg};
            end
            OP_I: begin
                a_next = {integ_gain_reg[SAMPLE_W-1], integ_gain_reg};
                b_next = {{(OPB_W-ERR_W){error_sum_reg[ERR_W-1]}}, error_sum_reg};
            end
            OP_D: begin
                a_next = {deriv_gain_reg[SAMPLE_W-1], deriv_gain_reg};
                b_next = {{(OPB_W-DIFF_W){err_diff[DIFF_W-1]}}, err_diff};
            end
            OP_B: begin
                // prev * 2^16 + w * (raw - prev)
                a_next   = {{(MUL_A_W-BLEND_W){1'b0}}, blend_w};
                b_next   = blend_diff;
                acc_init = {{(ACC_W-TERM_W-BLEND_BITS){prev_deriv_reg[TERM_W-1]}},
                            prev_deriv_reg, {BLEND_BITS{1'b0}}};
            end
            default: begin
                a_next = '0;
            end
        endcase
    end

    // shared multiplier, low chunk unsigned, last chunk signed
    assign mul_b     = cmd.mul_last ? b_reg[MUL_B_W-1:0] : {1'b0, b_reg[CHUNK_W-1:0]};
    assign prod_next = a_reg * mul_b;
    assign prod_shift = prod_hi_reg ? {prod_reg[ACC_W-1-CHUNK_W:0], {CHUNK_W{1'b0}}} : prod_reg;

    always_ff @(posedge aclk) begin
        if (cmd.op_load) begin
            a_reg       <= a_next;
            b_reg       <= b_next;
            mul_idx_reg <= 1'b0;
        end else if (cmd.mul_en) begin
            b_reg       <= b_reg >>> CHUNK_W;
            mul_idx_reg <= 1'b1;
        end
        if (cmd.mul_en) begin
            prod_reg    <= prod_next;
            prod_hi_reg <= mul_idx_reg;
        end
        if (cmd.op_load) begin
            acc_reg <= acc_init;
        end else if (cmd.acc_en) begin
            acc_reg <= acc_reg + prod_shift;
        end
    end

    // floor shift and 48-bit saturation of a gain product
    assign q_shift     = acc_reg >>> FRAC_BITS;
    assign blend_shift = acc_reg >>> BLEND_BITS;
    assign q_in_range  = (&q_shift[ACC_W-1:TERM_W-1]) || !(|q_shift[ACC_W-1:TERM_W-1]);
    assign q_sat       = q_in_range ? q_shift[TERM_W-1:0]
                       : (q_shift[ACC_W-1] ? {1'b1, {(TERM_W-1){1'b0}}}
                                           : {1'b0, {(TERM_W-1){1'b1}}});

    always_ff @(posedge aclk) begin
        if (cmd.store_en) begin
            case (cmd.dst)
                DST_P:   p_term_reg <= q_sat;
                DST_I:   i_term_reg <= q_sat;
                DST_RAW: raw_reg    <= q_sat;
                default: raw_reg    <= q_sat;
            endcase
        end
    end

    // output sum and clamp
    assign total_next = {{(TOTAL_W-TERM_W){p_term_reg[TERM_W-1]}}, p_term_reg}
                      + {{(TOTAL_W-TERM_W){i_term_reg[TERM_W-1]}}, i_term_reg}
                      + {{(TOTAL_W-TERM_W){prev_deriv_reg[TERM_W-1]}}, prev_deriv_reg};
    assign olim = {{(TOTAL_W-LIMIT_W){1'b0}}, out_limit_reg};

    always_comb begin
        if (total_reg > olim) begin
            out_clamped = olim;
        end else if (total_reg < -olim) begin
            out_clamped = -olim;
        end else begin
            out_clamped = total_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.total_load) begin
            total_reg <= total_next;
        end
        if (cmd.out_load) begin
            drive_reg <= out_clamped[SAMPLE_W-1:0];
        end
    end

    assign m_drive = drive_reg;

endmodule

[rtl/core/pid_filtered_derivative.sv]
// channel   direction  ports                                   moves
// s_        in         s_valid/s_ready, command,target,measured one request per command
// m_        out        m_valid/m_ready, drive                   one result per compute
// cfg_      in         cfg_we, cfg_index, cfg_data              register write, no wait
//
// a compute request runs through every sequencer state from acceptance to m_valid, and the next
// request is taken only after the sequencer has returned to idle, so computes never overlap;
// the sequencer steps five chunked products through one shared 33x35 multiplier
// clear and reset requests are handled in idle and give no result
// reset is synchronous, active low, and restores register defaults and zero state
// a new result holds the last step until m_ready while an earlier result still waits, s_ready stays low meanwhile
module pid_filtered_derivative #(
    parameter int FRAC_BITS = pfd_pkg::FRAC_BITS_DEF
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic [pfd_pkg::CMD_W-1:0]             s_command,
    input  logic signed [pfd_pkg::SAMPLE_W-1:0]   s_target,
    input  logic signed [pfd_pkg::SAMPLE_W-1:0]   s_measured,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic signed [pfd_pkg::SAMPLE_W-1:0]   m_drive,
    input  logic                                  cfg_we,
    input  logic [pfd_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [pfd_pkg::CFG_DATA_W-1:0]        cfg_data
);
    import pfd_pkg::*;

    pfd_cmd_t cmd;

    pfd_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_command (s_command),
        .s_ready   (s_ready),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .cmd       (cmd)
    );

    pfd_dpath #(
        .FRAC_BITS (FRAC_BITS)
    ) u_dpath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .s_target   (s_target),
        .s_measured (s_measured),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .m_drive    (m_drive)
    );

endmodule
